/* hdl/tccb_pkg.sv */
// ----------------------------------------------------------------------------
// tccb_pkg: text console cell buffer package
// Request codes, queue entry, configuration and sequencer state types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccb_pkg;

  typedef enum logic [3:0] {
    REQ_PUT     = 4'd0,
    REQ_MOVE    = 4'd1,
    REQ_NEWLINE = 4'd2,
    REQ_CLRLINE = 4'd3,
    REQ_CLRSCR  = 4'd4,
    REQ_ATTR    = 4'd5,
    REQ_SAVE    = 4'd6,
    REQ_RESTORE = 4'd7,
    REQ_READ    = 4'd8
  } req_t;

  localparam logic [1:0] CFG_COLS   = 2'd0;
  localparam logic [1:0] CFG_ROWS   = 2'd1;
  localparam logic [1:0] CFG_STATUS = 2'd2;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HIGHBIT = 8'h80;
  localparam logic [7:0] CH_BANNER  = 8'hA0;

  // effective sizes as seen by the datapath
  typedef struct packed {
    logic [6:0] ecols;
    logic [5:0] erows;
    logic [4:0] status;
  } cfg_t;

  // one classified request
  typedef struct packed {
    req_t       op;
    logic [7:0] ch;
    logic [5:0] trow;
    logic [6:0] tcol;
    logic [7:0] attr;
  } q_entry_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_MV_RD, ST_MV_WR, ST_SC_RD, ST_SC_WR,
    ST_ZERO, ST_CLR, ST_RD_WAIT, ST_DONE
  } state_t;

  function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] hi);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

/* hdl/tccb_front.sv */
// ----------------------------------------------------------------------------
// tccb_front: request front end
// Accepts request beats, saturates targets and queues them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccb_front
  import tccb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  back_status_t bstat,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [3:0]   in_req_type,
  input  logic [7:0]   in_char_code,
  input  logic [5:0]   in_target_row,
  input  logic [6:0]   in_target_col,
  input  logic [7:0]   in_attr_value,
  output logic         q_valid,
  output q_entry_t     q_entry,
  input  logic         q_pop
);

  q_entry_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  q_entry_t   ent;

  assign in_stall = (count_r == 2'd2) || bstat.init_busy;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_entry  = q_r[rd_ptr_r];

  // classify and saturate the incoming beat
  always_comb begin
    ent.op   = req_t'(in_req_type);
    ent.ch   = in_char_code;
    ent.trow = 6'(clamp7({1'b0, in_target_row}, {1'b0, cfg.erows}));
    ent.tcol = clamp7(in_target_col, cfg.ecols);
    ent.attr = in_attr_value;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= ent;
    end
  end

endmodule

/* hdl/tccb_back.sv */
// ----------------------------------------------------------------------------
// tccb_back: request execution
// Screen memory, cursor state and the sequencer that walks cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccb_back
  import tccb_pkg::*;
#(
  parameter int BUFFER_COLS = 64,
  parameter int BUFFER_ROWS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  output back_status_t bstat,
  input  logic         q_valid,
  input  q_entry_t     q_entry,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [5:0]   out_cursor_row_out,
  output logic [6:0]   out_cursor_col_out,
  output logic [7:0]   out_cell_value,
  output logic         out_saved_out
);

  localparam int CELLS = BUFFER_COLS * BUFFER_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_LEN   = AW'(BUFFER_COLS);
  localparam logic [AW-1:0] SCR_LAST  = AW'((BUFFER_ROWS - 1) * BUFFER_COLS - 1);

  function automatic logic [AW-1:0] row_base(input logic [5:0] row);
    logic [31:0] t;
    t = (32'(row) - 32'd1) * 32'(BUFFER_COLS);
    return t[AW-1:0];
  endfunction

  logic [7:0]    mem [CELLS];
  logic [7:0]    rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  state_t        state_r, state_nxt;
  logic [5:0]    row_r, row_nxt, srow_r, srow_nxt;
  logic [6:0]    col_r, col_nxt, scol_r, scol_nxt;
  logic          svalid_r, svalid_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt, last_r, last_nxt;
  logic [7:0]    cell_r, cell_nxt;
  logic          ov_r, ov_nxt;
  logic [5:0]    orow_r, orow_nxt;
  logic [6:0]    ocol_r, ocol_nxt;
  logic [7:0]    ocell_r, ocell_nxt;
  logic          osav_r, osav_nxt;

  logic [6:0]    mrow7, mcol;
  logic [5:0]    mrow;
  logic [6:0]    row_inc;

  assign bstat.init_busy    = (state_r == ST_INIT);
  assign out_valid          = ov_r;
  assign out_cursor_row_out = orow_r;
  assign out_cursor_col_out = ocol_r;
  assign out_cell_value     = ocell_r;
  assign out_saved_out      = osav_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    srow_nxt   = srow_r;
    scol_nxt   = scol_r;
    svalid_nxt = svalid_r;
    attr_nxt   = attr_r;
    ptr_nxt    = ptr_r;
    last_nxt   = last_r;
    cell_nxt   = cell_r;
    ov_nxt     = ov_r && out_stall;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    ocell_nxt  = ocell_r;
    osav_nxt   = osav_r;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ptr_r;
    mem_wdata  = 8'h00;
    mem_raddr  = ptr_r;
    mrow7      = 7'd1;
    mrow       = 6'd1;
    mcol       = 7'd1;
    row_inc    = {1'b0, row_r} + 7'd1;

    unique case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = (ptr_r < ROW_LEN) ? CH_BANNER : 8'h00;
        ptr_nxt   = ptr_r + AW'(1);
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cell_nxt  = 8'h00;
          state_nxt = ST_DONE;
          unique case (q_entry.op)
            REQ_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = row_base(row_r) + AW'(col_r - 7'd1);
              mem_wdata = attr_r[0] ? (q_entry.ch | CH_HIGHBIT) : q_entry.ch;
              col_nxt   = (col_r + 7'd1 > cfg.ecols) ? cfg.ecols : col_r + 7'd1;
            end
            REQ_MOVE, REQ_RESTORE: begin
              if (q_entry.op == REQ_MOVE || svalid_r) begin
                if (q_entry.op == REQ_MOVE) begin
                  mrow = q_entry.trow;
                  mcol = q_entry.tcol;
                end else begin
                  mrow7      = clamp7({1'b0, srow_r}, {1'b0, cfg.erows});
                  mrow       = mrow7[5:0];
                  mcol       = clamp7(scol_r, cfg.ecols);
                  svalid_nxt = 1'b0;
                end
                row_nxt  = mrow;
                col_nxt  = mcol;
                ptr_nxt  = row_base(mrow);
                last_nxt = row_base(mrow) + AW'(mcol - 7'd2);
                if (mcol != 7'd1) begin
                  state_nxt = ST_MV_RD;
                end
              end
            end
            REQ_NEWLINE: begin
              col_nxt = 7'd1;
              if (row_inc > {1'b0, cfg.erows}) begin
                row_nxt = cfg.erows;
                if (32'(cfg.status) >= BUFFER_ROWS - 1) begin
                  ptr_nxt   = row_base(cfg.erows);
                  last_nxt  = row_base(cfg.erows) + ROW_LEN - AW'(1);
                  state_nxt = ST_ZERO;
                end else begin
                  ptr_nxt   = AW'(32'(cfg.status) * 32'(BUFFER_COLS));
                  last_nxt  = SCR_LAST;
                  state_nxt = ST_SC_RD;
                end
              end else begin
                row_nxt = row_inc[5:0];
              end
            end
            REQ_CLRLINE: begin
              ptr_nxt   = row_base(row_r);
              last_nxt  = row_base(row_r) + ROW_LEN - AW'(1);
              state_nxt = ST_ZERO;
            end
            REQ_CLRSCR: begin
              row_nxt   = 6'd1;
              col_nxt   = 7'd1;
              ptr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            REQ_ATTR: begin
              attr_nxt = q_entry.attr;
            end
            REQ_SAVE: begin
              if (!svalid_r) begin
                srow_nxt   = row_r;
                scol_nxt   = col_r;
                svalid_nxt = 1'b1;
              end
            end
            REQ_READ: begin
              mem_raddr = row_base(q_entry.trow) + AW'(q_entry.tcol - 7'd1);
              state_nxt = ST_RD_WAIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MV_RD: begin
        state_nxt = ST_MV_WR;
      end
      ST_MV_WR: begin
        mem_we    = (rdata_r == 8'h00);
        mem_wdata = CH_SPACE;
        ptr_nxt   = ptr_r + AW'(1);
        state_nxt = (ptr_r == last_r) ? ST_DONE : ST_MV_RD;
      end
      ST_SC_RD: begin
        mem_raddr = ptr_r + ROW_LEN;
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_r;
        ptr_nxt   = ptr_r + AW'(1);
        state_nxt = ST_SC_RD;
        if (ptr_r == last_r) begin
          ptr_nxt   = row_base(cfg.erows);
          last_nxt  = row_base(cfg.erows) + ROW_LEN - AW'(1);
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CLR: begin
        mem_we  = 1'b1;
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_WAIT: begin
        cell_nxt  = rdata_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          orow_nxt  = row_r;
          ocol_nxt  = col_r;
          ocell_nxt = cell_r;
          osav_nxt  = svalid_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      row_r    <= 6'd1;
      col_r    <= 7'd1;
      srow_r   <= 6'd0;
      scol_r   <= 7'd0;
      svalid_r <= 1'b0;
      attr_r   <= 8'h00;
      ptr_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      srow_r   <= srow_nxt;
      scol_r   <= scol_nxt;
      svalid_r <= svalid_nxt;
      attr_r   <= attr_nxt;
      ptr_r    <= ptr_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    cell_r  <= cell_nxt;
    orow_r  <= orow_nxt;
    ocol_r  <= ocol_nxt;
    ocell_r <= ocell_nxt;
    osav_r  <= osav_nxt;
  end

  // screen memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("queue popped outside idle");
  a_row_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r != 6'd0) && (col_r != 7'd0))
    else $error("cursor at zero");
  a_mv_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MV_WR) |-> ($past(state_r) == ST_MV_RD))
    else $error("move write without read");
  a_init_nopop: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.init_busy |-> !q_pop && !ov_r)
    else $error("activity during clearing pass");
`endif

endmodule

/* hdl/text_console_cell_buffer.sv */
// Path: queue, sequencer, output registers (a read adds a memory wait), plus a walk: move or
//   restore over cells left of cursor, clear line over a row, scroll over moved cells + a row.
// Clear screen sweeps all BUFFER_COLS*BUFFER_ROWS cells, one per cycle.
// Throughput: one request at a time; a two-beat queue keeps taking beats while busy until it is full.
// Reset: synchronous; a clearing pass over all BUFFER_COLS*BUFFER_ROWS cells
//   writes the first row to 0xA0 and the rest to 0 while requests are stalled.
// ----------------------------------------------------------------------------
// text_console_cell_buffer: character-cell console top level
// Configuration registers, request front end and execution back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cell_buffer
  import tccb_pkg::*;
#(
  parameter int BUFFER_COLS = 64,
  parameter int BUFFER_ROWS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_req_type,
  input  logic [7:0] in_char_code,
  input  logic [5:0] in_target_row,
  input  logic [6:0] in_target_col,
  input  logic [7:0] in_attr_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_cursor_row_out,
  output logic [6:0] out_cursor_col_out,
  output logic [7:0] out_cell_value,
  output logic       out_saved_out
);

  logic [6:0]   vcols_r;
  logic [5:0]   vrows_r;
  logic [4:0]   status_r;
  cfg_t         cfg;
  back_status_t bstat;
  logic         q_valid, q_pop;
  q_entry_t     q_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcols_r  <= 7'd64;
      vrows_r  <= 6'd32;
      status_r <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLS:   vcols_r  <= cfg_data;
        CFG_ROWS:   vrows_r  <= cfg_data[5:0];
        CFG_STATUS: status_r <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // effective sizes
  always_comb begin
    if (vcols_r == 7'd0) cfg.ecols = 7'd1;
    else if (9'(vcols_r) > 9'(BUFFER_COLS)) cfg.ecols = 7'(BUFFER_COLS);
    else cfg.ecols = vcols_r;
    if (vrows_r == 6'd0) cfg.erows = 6'd1;
    else if (7'(vrows_r) > 7'(BUFFER_ROWS)) cfg.erows = 6'(BUFFER_ROWS);
    else cfg.erows = vrows_r;
    cfg.status = status_r;
  end

  tccb_front u_front (
    .clk, .rst_n, .cfg, .bstat,
    .in_valid, .in_stall, .in_req_type, .in_char_code,
    .in_target_row, .in_target_col, .in_attr_value,
    .q_valid, .q_entry, .q_pop
  );

  tccb_back #(.BUFFER_COLS(BUFFER_COLS), .BUFFER_ROWS(BUFFER_ROWS)) u_back (
    .clk, .rst_n, .cfg, .bstat,
    .q_valid, .q_entry, .q_pop,
    .out_valid, .out_stall, .out_cursor_row_out, .out_cursor_col_out,
    .out_cell_value, .out_saved_out
  );

endmodule
